@@ src/ukt_pkg.sv @@
// types and codes shared by the unique key table and its channels
package ukt_pkg;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_FIND   = 2'd2,
      KIND_SPARE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_DUPLICATE = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] key;
      logic [15:0] handle;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  position;
      logic [15:0] removed_handle;
      logic [4:0]  entry_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] key;
      logic [15:0] handle;
   } entry_type;

endpackage

@@ src/ukt_stream_if.sv @@
// valid/ready channel with a typed payload
interface ukt_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ src/unique_key_table_compacting.sv @@
// unique key table: packed key/handle list with add, remove (shift down) and find
//
// req_chan carries one operation per transfer (kind, key, handle); rsp_chan returns
// exactly one result per operation (status, position, removed_handle, entry_count).
// Entries live in one synchronous memory of CAPACITY words that is read one slot
// per cycle. A lookup streams slots 0..n-1 through the read port, one per cycle,
// and stops at the first match. A remove then streams the later slots back one
// place down, reading one slot and writing the previous one each cycle.
// An add to a full or empty table and any lookup on an empty table go straight to
// the result without a scan. Any other lookup ends at the first match or, on a
// miss, at slot n-1, and a remove then adds the shift of the later slots. One item
// is in work at a time; the next one is taken once the result sits in the output
// register, even while that result waits to be taken. If the receiver stalls and a
// second result is ready, the sequencer holds until the output register is free.
// Reset empties the table (the count goes to zero) and drops any pending result;
// the memory contents are not cleared, since only slots below the count are read.
module unique_key_table_compacting
   import ukt_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic         clock,
   input  logic         reset,
   ukt_stream_if.sink   req_chan,
   ukt_stream_if.source rsp_chan
);

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int SCAN_W = CNT_W + 1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // entry memory
   entry_type entry_mem [CAPACITY];
   entry_type rd_data_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr;

   state_type state_ff, state_in;

   logic [1:0]  kind_ff, kind_in;
   logic [15:0] key_ff, key_in;
   logic [15:0] handle_ff, handle_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;

   logic [1:0]       pend_status_ff, pend_status_in;
   logic [IDX_W-1:0] pend_pos_ff, pend_pos_in;
   logic [15:0]      pend_handle_ff, pend_handle_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic             req_ready;
   logic             req_fire;
   logic             table_full;
   logic             table_empty;
   logic             scan_ok;
   logic             hit;
   logic             miss_end;
   logic             out_free;
   logic [CNT_W-1:0] cnt_dec;
   logic [IDX_W-1:0] last_idx;
   logic [15:0]      pos_wide;
   logic [15:0]      cnt_wide;

   assign req_ready         = (state_ff == ST_IDLE);
   assign req_chan.ready    = req_ready;
   assign req_fire          = req_chan.valid && req_ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.payload  = rsp_data_ff;

   assign table_full  = (count_ff == CAP_CNT);
   assign table_empty = (count_ff == '0);
   assign scan_ok     = (scan_ff < SCAN_W'(count_ff));
   assign cnt_dec     = count_ff - CNT_W'(1);
   assign last_idx    = cnt_dec[IDX_W-1:0];
   assign hit         = chk_valid_ff && (rd_data_ff.key == key_ff);
   assign miss_end    = chk_valid_ff && !hit && (chk_idx_ff == last_idx);
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign rd_addr     = scan_ff[IDX_W-1:0];
   assign pos_wide    = 16'(pend_pos_ff);
   assign cnt_wide    = 16'(count_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if ((req_chan.payload.kind == KIND_ADD) && table_full) begin
                  state_in = ST_DONE;
               end else if (table_empty) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = (kind_ff == KIND_REMOVE) ? ST_SHIFT : ST_DONE;
            end else if (miss_end) begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT: begin
            if (!chk_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      kind_in        = kind_ff;
      key_in         = key_ff;
      handle_in      = handle_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      chk_valid_in   = 1'b0;
      chk_idx_in     = chk_idx_ff;
      pend_status_in = pend_status_ff;
      pend_pos_in    = pend_pos_ff;
      pend_handle_in = pend_handle_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in    = rsp_data_ff;
      wr_en          = 1'b0;
      wr_addr        = count_ff[IDX_W-1:0];
      wr_data        = '{key: key_ff, handle: handle_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in        = req_chan.payload.kind;
               key_in         = req_chan.payload.key;
               handle_in      = req_chan.payload.handle;
               scan_in        = '0;
               pend_status_in = STAT_OK;
               pend_pos_in    = '0;
               pend_handle_in = '0;
               if (req_chan.payload.kind == KIND_ADD) begin
                  if (table_full) begin
                     pend_status_in = STAT_FULL;
                  end else if (table_empty) begin
                     wr_en    = 1'b1;
                     wr_data  = '{key: req_chan.payload.key, handle: req_chan.payload.handle};
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (table_empty) begin
                  pend_status_in = STAT_NOT_FOUND;
               end
            end
         end
         ST_SCAN: begin
            // read port runs one slot ahead of the compare
            scan_in      = scan_ff + SCAN_W'(1);
            chk_valid_in = scan_ok;
            chk_idx_in   = scan_ff[IDX_W-1:0];
            if (hit) begin
               pend_pos_in = chk_idx_ff;
               case (kind_ff)
                  KIND_ADD:    pend_status_in = STAT_DUPLICATE;
                  KIND_REMOVE: pend_handle_in = rd_data_ff.handle;
                  default:     pend_status_in = STAT_OK;
               endcase
            end else if (miss_end) begin
               if (kind_ff == KIND_ADD) begin
                  wr_en       = 1'b1;
                  pend_pos_in = count_ff[IDX_W-1:0];
                  count_in    = count_ff + CNT_W'(1);
               end else begin
                  pend_status_in = STAT_NOT_FOUND;
               end
            end
         end
         ST_SHIFT: begin
            scan_in      = scan_ff + SCAN_W'(1);
            chk_valid_in = scan_ok;
            chk_idx_in   = scan_ff[IDX_W-1:0];
            if (chk_valid_ff) begin
               // move the slot just read one place down
               wr_en   = 1'b1;
               wr_addr = chk_idx_ff - IDX_W'(1);
               wr_data = rd_data_ff;
            end else begin
               count_in = cnt_dec;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.status         = pend_status_ff;
               rsp_data_in.position       = pos_wide[3:0];
               rsp_data_in.removed_handle = pend_handle_ff;
               rsp_data_in.entry_count    = cnt_wide[4:0];
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      handle_ff      <= handle_in;
      scan_ff        <= scan_in;
      chk_idx_ff     <= chk_idx_in;
      pend_status_ff <= pend_status_in;
      pend_pos_ff    <= pend_pos_in;
      pend_handle_ff <= pend_handle_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // the table never holds more than its capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   // a new result only appears when the sequencer finishes an item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_chan.ready) && !$past(reset))
      |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside of completion");

   // the shift never writes below slot zero
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && chk_valid_ff) |-> (chk_idx_ff != '0))
      else $error("shift write wrapped below slot zero");

   // the count moves by at most one per item, and never while a result is held in ST_DONE
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |-> ($past(state_ff) != ST_DONE))
      else $error("entry count changed while holding a result");

endmodule
